### design/lds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lds_pkg;

  localparam int TagW  = 48;
  localparam int StorW = 16;
  localparam int KeyW  = 32;

  typedef enum logic [1:0] {
    K_INSERT  = 2'd0,
    K_CLEAN   = 2'd1,
    K_COLLECT = 2'd2,
    K_TRIM    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_HIT       = 3'd1,
    ST_FULL      = 3'd2,
    ST_ABSENT    = 3'd3,
    ST_COLLECTED = 3'd4,
    ST_NONE      = 3'd5
  } status_e;

  // final action taken once the scans are over
  typedef enum logic [2:0] {
    A_HIT,
    A_CLEAN,
    A_ABSENT,
    A_NONE,
    A_PLACE,
    A_FULL,
    A_TRIM
  } act_e;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_CMP   = 6'b000100,
    S_VSCAN = 6'b001000,
    S_DEC   = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

  localparam logic [2:0] RegMaxEntries = 3'd0;

endpackage
`default_nettype wire

### design/lds_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface lds_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] storage_id;
  logic [31:0] block_key;
  logic        make_dirty;
  modport source (output valid, kind, storage_id, block_key, make_dirty, input ready);
  modport sink   (input valid, kind, storage_id, block_key, make_dirty, output ready);
endinterface

interface lds_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  slot;
  logic [15:0] out_storage;
  logic [31:0] out_key;
  logic [4:0]  evicted;
  logic [4:0]  occupancy;
  logic [4:0]  dirty_total;
  logic        last;
  modport source (output valid, status, slot, out_storage, out_key, evicted, occupancy,
                  dirty_total, last, input ready);
  modport sink   (input valid, status, slot, out_storage, out_key, evicted, occupancy,
                  dirty_total, last, output ready);
endinterface
`default_nettype wire

### design/lru_dirty_tag_store_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Fully associative tag store with valid/dirty marks and LRU ranking.
// in_i takes one command per transfer (insert, mark clean, collect dirty
// entries of a storage, trim to limit); out_o returns one result per
// command, or one per collected entry with last set on the final one.
// The eviction limit is written over the APB port at byte addresses 0 to 3
// and read back at address 0; the user writes it only while idle, which the
// block does not enforce. One command is handled at a time; in_i.ready is
// high only when idle. Tags live in a memory with a registered read port and
// a separate write port; a lookup reads each slot in an S_RD step and
// compares it in an S_CMP step. Each eviction is a walk over the rank
// registers (S_VSCAN) followed by an S_DEC step; collect walks the memory
// twice (count, then report). Results sit in an output register; a stalled
// receiver holds the block in its final step (or mid-collect) until the result is taken.
// Reset empties the store at once (valid and dirty flops cleared), sets
// the eviction limit to 16; the tag memory needs no clearing.
module lru_dirty_tag_store_top #(
  parameter int CAPACITY = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  lds_in_if.sink      in_i,
  lds_out_if.source   out_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > 5) ? CW : 5;
  localparam logic [IW-1:0] LastIdx = IW'(CAPACITY - 1);

  // configuration
  logic [4:0] max_q;
  wire cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr == lds_pkg::RegMaxEntries) ? {27'd0, max_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= 5'd16;
    end else if (cfg_wr && paddr[2] == 1'b0) begin
      max_q <= pwdata[4:0];
    end
  end

  // tag memory
  logic [lds_pkg::TagW-1:0] mem [CAPACITY];
  logic [lds_pkg::TagW-1:0] rdata_q;
  logic                     mem_we;
  logic [IW-1:0]            mem_wa;

  // control and lane state
  lds_pkg::state_e state_q, state_d;
  lds_pkg::act_e   act_q, act_d;
  lds_pkg::kind_e  kind_q, kind_d;
  logic [lds_pkg::TagW-1:0] tag_q, tag_d;
  logic            mkd_q, mkd_d;
  logic [IW-1:0]   idx_q, idx_d, fslot_q, fslot_d, vic_q, vic_d, free_q, free_d;
  logic [IW-1:0]   fage_q, fage_d, vage_q, vage_d;
  logic            vf_q, vf_d, ff_q, ff_d, pass2_q, pass2_d;
  logic [CW-1:0]   cnt_q, cnt_d, dcnt_q, dcnt_d, ev_q, ev_d, ncol_q, ncol_d, kcol_q, kcol_d;
  logic [CAPACITY-1:0] valid_q, valid_d, dirty_q, dirty_d;
  logic [IW-1:0]   age_q [CAPACITY];
  logic [IW-1:0]   age_d [CAPACITY];

  // output register
  logic            out_vld_q;
  logic [2:0]      o_status_q;
  logic [3:0]      o_slot_q;
  logic [15:0]     o_stor_q;
  logic [31:0]     o_key_q;
  logic [4:0]      o_ev_q, o_occ_q, o_dcnt_q;
  logic            o_last_q;

  logic            can_emit, emit, e_last, m_find, m_col, need_ev;
  lds_pkg::status_e e_status;
  logic [IW-1:0]   e_slot;
  logic [lds_pkg::TagW-1:0] e_tag;
  logic [CW-1:0]   e_ev;
  logic [IW-1:0]   cur_age;

  assign in_i.ready = (state_q == lds_pkg::S_IDLE);
  assign cur_age    = age_q[idx_q];
  assign m_find     = valid_q[idx_q] && (rdata_q == tag_q);
  assign m_col      = valid_q[idx_q] && dirty_q[idx_q] &&
                      (rdata_q[lds_pkg::TagW-1:lds_pkg::KeyW] == tag_q[lds_pkg::TagW-1:lds_pkg::KeyW]);
  assign need_ev    = (kind_q == lds_pkg::K_INSERT) ? (MW'(cnt_q) >= MW'(max_q))
                                                    : (MW'(cnt_q) >  MW'(max_q));

  // sequencer
  always_comb begin
    state_d = state_q; act_d = act_q; kind_d = kind_q; tag_d = tag_q; mkd_d = mkd_q;
    idx_d = idx_q; fslot_d = fslot_q; vic_d = vic_q; free_d = free_q;
    fage_d = fage_q; vage_d = vage_q; vf_d = vf_q; ff_d = ff_q; pass2_d = pass2_q;
    cnt_d = cnt_q; dcnt_d = dcnt_q; ev_d = ev_q; ncol_d = ncol_q; kcol_d = kcol_q;
    valid_d = valid_q; dirty_d = dirty_q; age_d = age_q;
    mem_we = 1'b0; mem_wa = free_q;
    can_emit = !out_vld_q || out_o.ready;
    emit = 1'b0; e_status = lds_pkg::ST_DONE; e_slot = '0; e_tag = '0;
    e_ev = '0; e_last = 1'b1;

    unique case (state_q)
      lds_pkg::S_IDLE: begin
        if (in_i.valid) begin
          kind_d  = lds_pkg::kind_e'(in_i.kind);
          tag_d   = {in_i.storage_id, in_i.block_key};
          mkd_d   = in_i.make_dirty;
          idx_d   = '0; ev_d = '0; vf_d = 1'b0; ff_d = 1'b0;
          pass2_d = 1'b0; ncol_d = '0; kcol_d = '0;
          state_d = (lds_pkg::kind_e'(in_i.kind) == lds_pkg::K_TRIM) ? lds_pkg::S_VSCAN
                                                                     : lds_pkg::S_RD;
        end
      end
      lds_pkg::S_RD: state_d = lds_pkg::S_CMP;
      lds_pkg::S_CMP: begin
        if (kind_q == lds_pkg::K_COLLECT) begin
          if (!pass2_q) begin
            ncol_d = ncol_q + CW'(m_col);
            if (idx_q == LastIdx) begin
              if (ncol_d == '0) begin
                act_d = lds_pkg::A_NONE; state_d = lds_pkg::S_FIN;
              end else begin
                dcnt_d = dcnt_q - ncol_d; pass2_d = 1'b1; idx_d = '0;
                state_d = lds_pkg::S_RD;
              end
            end else begin
              idx_d = idx_q + 1'b1; state_d = lds_pkg::S_RD;
            end
          end else if (!m_col || can_emit) begin
            // report one collected entry
            if (m_col) begin
              emit = 1'b1; e_status = lds_pkg::ST_COLLECTED; e_slot = idx_q;
              e_tag = rdata_q; e_last = (kcol_q + 1'b1 == ncol_q);
              dirty_d[idx_q] = 1'b0; kcol_d = kcol_q + 1'b1;
            end
            if (idx_q == LastIdx) begin
              state_d = lds_pkg::S_IDLE;
            end else begin
              idx_d = idx_q + 1'b1; state_d = lds_pkg::S_RD;
            end
          end
        end else begin
          // lookup for insert or mark clean
          if (m_find) begin
            fslot_d = idx_q; fage_d = cur_age;
            act_d = (kind_q == lds_pkg::K_INSERT) ? lds_pkg::A_HIT : lds_pkg::A_CLEAN;
            state_d = lds_pkg::S_FIN;
          end else if (idx_q == LastIdx) begin
            idx_d = '0;
            if (kind_q == lds_pkg::K_INSERT) begin
              state_d = lds_pkg::S_VSCAN;
            end else begin
              act_d = lds_pkg::A_ABSENT; state_d = lds_pkg::S_FIN;
            end
          end else begin
            idx_d = idx_q + 1'b1; state_d = lds_pkg::S_RD;
          end
        end
      end
      lds_pkg::S_VSCAN: begin
        // oldest clean entry and first free slot
        if (valid_q[idx_q] && !dirty_q[idx_q] && (!vf_q || cur_age > vage_q)) begin
          vf_d = 1'b1; vic_d = idx_q; vage_d = cur_age;
        end
        if (!valid_q[idx_q] && !ff_q) begin
          ff_d = 1'b1; free_d = idx_q;
        end
        if (idx_q == LastIdx) state_d = lds_pkg::S_DEC;
        else idx_d = idx_q + 1'b1;
      end
      lds_pkg::S_DEC: begin
        if (need_ev && vf_q) begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (valid_q[i] && age_q[i] > vage_q) age_d[i] = age_q[i] - 1'b1;
          end
          valid_d[vic_q] = 1'b0; age_d[vic_q] = '0;
          cnt_d = cnt_q - 1'b1; ev_d = ev_q + 1'b1;
          idx_d = '0; vf_d = 1'b0; ff_d = 1'b0;
          state_d = lds_pkg::S_VSCAN;
        end else begin
          state_d = lds_pkg::S_FIN;
          if (kind_q == lds_pkg::K_TRIM) act_d = lds_pkg::A_TRIM;
          else if (ff_q) act_d = lds_pkg::A_PLACE;
          else act_d = lds_pkg::A_FULL;
        end
      end
      lds_pkg::S_FIN: begin
        if (can_emit) begin
          emit = 1'b1; state_d = lds_pkg::S_IDLE; e_ev = ev_q;
          unique case (act_q)
            lds_pkg::A_HIT: begin
              e_status = lds_pkg::ST_HIT; e_slot = fslot_q; e_ev = '0;
              if (mkd_q && !dirty_q[fslot_q]) dcnt_d = dcnt_q + 1'b1;
              else if (!mkd_q && dirty_q[fslot_q]) dcnt_d = dcnt_q - 1'b1;
              dirty_d[fslot_q] = mkd_q;
              for (int i = 0; i < CAPACITY; i++) begin
                if (valid_q[i] && age_q[i] < fage_q) age_d[i] = age_q[i] + 1'b1;
              end
              age_d[fslot_q] = '0;
            end
            lds_pkg::A_CLEAN: begin
              e_slot = fslot_q; e_ev = '0;
              if (dirty_q[fslot_q]) begin
                dirty_d[fslot_q] = 1'b0; dcnt_d = dcnt_q - 1'b1;
              end
            end
            lds_pkg::A_ABSENT: begin
              e_status = lds_pkg::ST_ABSENT; e_ev = '0;
            end
            lds_pkg::A_NONE: begin
              e_status = lds_pkg::ST_NONE; e_ev = '0;
            end
            lds_pkg::A_PLACE: begin
              e_slot = free_q;
              for (int i = 0; i < CAPACITY; i++) begin
                if (valid_q[i]) age_d[i] = age_q[i] + 1'b1;
              end
              valid_d[free_q] = 1'b1; dirty_d[free_q] = mkd_q; age_d[free_q] = '0;
              mem_we = 1'b1; mem_wa = free_q;
              cnt_d = cnt_q + 1'b1; dcnt_d = dcnt_q + CW'(mkd_q);
            end
            lds_pkg::A_FULL: e_status = lds_pkg::ST_FULL;
            lds_pkg::A_TRIM: e_status = lds_pkg::ST_DONE;
            default: e_status = lds_pkg::ST_DONE;
          endcase
        end
      end
      default: state_d = lds_pkg::S_IDLE;
    endcase
  end

  // tag memory port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= tag_q;
    rdata_q <= mem[idx_q];
  end

  // control and lane registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lds_pkg::S_IDLE;
      valid_q <= '0;
      dirty_q <= '0;
      cnt_q   <= '0;
      dcnt_q  <= '0;
      for (int i = 0; i < CAPACITY; i++) age_q[i] <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      dirty_q <= dirty_d;
      cnt_q   <= cnt_d;
      dcnt_q  <= dcnt_d;
      age_q   <= age_d;
    end
  end

  // working registers of the current command
  always_ff @(posedge clk_i) begin
    act_q <= act_d; kind_q <= kind_d; tag_q <= tag_d; mkd_q <= mkd_d;
    idx_q <= idx_d; fslot_q <= fslot_d; vic_q <= vic_d; free_q <= free_d;
    fage_q <= fage_d; vage_q <= vage_d; vf_q <= vf_d; ff_q <= ff_d;
    pass2_q <= pass2_d; ev_q <= ev_d; ncol_q <= ncol_d; kcol_q <= kcol_d;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      o_status_q <= e_status;
      o_slot_q   <= 4'(e_slot);
      o_stor_q   <= e_tag[lds_pkg::TagW-1:lds_pkg::KeyW];
      o_key_q    <= e_tag[lds_pkg::KeyW-1:0];
      o_ev_q     <= 5'(e_ev);
      o_occ_q    <= 5'(cnt_d);
      o_dcnt_q   <= 5'(dcnt_d);
      o_last_q   <= e_last;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.status      = o_status_q;
  assign out_o.slot        = o_slot_q;
  assign out_o.out_storage = o_stor_q;
  assign out_o.out_key     = o_key_q;
  assign out_o.evicted     = o_ev_q;
  assign out_o.occupancy   = o_occ_q;
  assign out_o.dirty_total = o_dcnt_q;
  assign out_o.last        = o_last_q;

endmodule
`default_nettype wire

### design/lds_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module lds_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [2:0]  status,
  input wire [4:0]  evicted,
  input wire [4:0]  occupancy,
  input wire [4:0]  dirty_total
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(evicted))
    else $error("stalled result changed");

  // one command at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while busy");

  // no status code beyond nothing collected
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> status <= lds_pkg::ST_NONE)
    else $error("bad status");

  // only insert and trim evict
  a_noev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (status == lds_pkg::ST_HIT || status == lds_pkg::ST_ABSENT ||
                  status == lds_pkg::ST_COLLECTED || status == lds_pkg::ST_NONE)
      |-> evicted == 5'd0)
    else $error("eviction on lookup or collect");

  // dirty entries are a subset of valid ones
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> dirty_total <= occupancy)
    else $error("dirty count above occupancy");

endmodule

bind lru_dirty_tag_store_top lds_checker u_lds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .status      (out_o.status),
  .evicted     (out_o.evicted),
  .occupancy   (out_o.occupancy),
  .dirty_total (out_o.dirty_total)
);
`default_nettype wire
